@@ hdl/ifpc_pkg.sv @@
// Shared types and constants for the idle framed packet checker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ifpc_pkg;

   localparam int unsigned MAX_FRAME = 256;

   localparam logic [8:0] MIN_FRAME = 9'd9;

   localparam logic [7:0] TAIL_Y = 8'h59;
   localparam logic [7:0] TAIL_H = 8'h48;
   localparam logic [7:0] TAIL_T = 8'h54;

   localparam logic [7:0] HEADER_FIRST_RESET  = 8'h59;
   localparam logic [7:0] HEADER_SECOND_RESET = 8'hA6;
   localparam logic [7:0] OWN_DEVICE_ID_RESET = 8'h01;

   localparam logic [1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [1:0] CSR_OWN_DEVICE_ID = 2'd2;

   typedef enum logic [1:0] {
      REQ_DATA    = 2'd0,
      REQ_IDLE    = 2'd1,
      REQ_OVERRUN = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_HEADER   = 3'd1,
      ST_TAIL     = 3'd2,
      ST_LENGTH   = 3'd3,
      ST_CHECKSUM = 3'd4,
      ST_DEVICE   = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] own_device_id;
   } cfg_type;

   // Status sits in the lowest bits, payload length in the highest.
   typedef struct packed {
      logic [7:0] payload_length;
      logic [8:0] frame_length;
      status_type frame_status;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/idle_framed_packet_checker.sv @@
// Top level of the idle framed packet checker: register port and channel glue.
// Instantiates ifpc_frame_track and ifpc_rsp_buf; depends on ifpc_pkg.
//
//   channel | direction | ports                                | content
//   req     | in        | req_tvalid req_tready req_tdata/tuser | receive event
//   rsp     | out       | rsp_tvalid rsp_tready rsp_tdata       | frame status
//   csr     | in        | csr_we csr_index csr_wdata            | header and id values
//
// One receive event is taken every cycle while req_tready is high; frame state updates at the accepting edge.
// An idle event's status is judged from the stored frame state and shows on rsp
// from the output register, entering through the skid register while a result is stalled.
// A two-entry result buffer keeps req_tready high while one result is stalled;
// it drops only when two results wait. Synchronous reset clears the frame state,
// empties the buffer and loads the register reset values.
`default_nettype none

module idle_framed_packet_checker #(
   parameter int unsigned MaxFrame = ifpc_pkg::MAX_FRAME
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] frame_status, [11:3] frame_length,
                                    // [19:12] payload_length, [23:20] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import ifpc_pkg::*;

   cfg_type cfg_ff;
   logic    accept;
   logic    done;
   rsp_type result;
   rsp_type out_data;
   logic    space;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= HEADER_FIRST_RESET;
         cfg_ff.header_second <= HEADER_SECOND_RESET;
         cfg_ff.own_device_id <= OWN_DEVICE_ID_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_FIRST:  cfg_ff.header_first  <= csr_wdata;
            CSR_HEADER_SECOND: cfg_ff.header_second <= csr_wdata;
            CSR_OWN_DEVICE_ID: cfg_ff.own_device_id <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   ifpc_frame_track #(
      .MaxFrame (MaxFrame)
   ) u_track (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_kind (req_kind_type'(req_tuser)),
      .rx_byte  (req_tdata),
      .cfg      (cfg_ff),
      .done     (done),
      .result   (result)
   );

   ifpc_rsp_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (done),
      .push_data (result),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {4'd0, out_data};

endmodule

`default_nettype wire

@@ hdl/ifpc_frame_track.sv @@
// Frame state of the checker: head bytes, five-byte tail window, count and sum.
// Judges a frame when the idle event arrives. Depends on ifpc_pkg.
`default_nettype none

module ifpc_frame_track #(
   parameter int unsigned MaxFrame = ifpc_pkg::MAX_FRAME
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ifpc_pkg::req_kind_type req_kind,
   input  logic [7:0]            rx_byte,
   input  ifpc_pkg::cfg_type     cfg,
   output logic                  done,
   output ifpc_pkg::rsp_type     result
);
   import ifpc_pkg::*;

   localparam logic [8:0] MaxCount = 9'(MaxFrame);

   logic [8:0]      byte_count_ff, byte_count_in;
   logic            overflowed_ff, overflowed_in;
   logic [3:0][7:0] head_ff, head_in;
   logic [4:0][7:0] tail_ff, tail_in;
   logic [15:0]     sum_ff, sum_in;
   status_type      status;

   always_comb begin
      byte_count_in = byte_count_ff;
      overflowed_in = overflowed_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      sum_in        = sum_ff;
      case (req_kind)
         REQ_DATA: begin
            if (byte_count_ff == MaxCount) begin
               overflowed_in = 1'b1;
            end else begin
               if (byte_count_ff < 9'd4) begin
                  head_in[byte_count_ff[1:0]] = rx_byte;
               end
               // The oldest window byte joins the sum as it leaves the window.
               if (byte_count_ff >= 9'd5) begin
                  sum_in = sum_ff + {8'd0, tail_ff[0]};
               end
               tail_in       = {rx_byte, tail_ff[4:1]};
               byte_count_in = byte_count_ff + 9'd1;
            end
         end
         REQ_IDLE, REQ_OVERRUN: begin
            byte_count_in = '0;
            overflowed_in = 1'b0;
            head_in       = '0;
            tail_in       = '0;
            sum_in        = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         overflowed_ff <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         sum_ff        <= '0;
      end else if (accept) begin
         byte_count_ff <= byte_count_in;
         overflowed_ff <= overflowed_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         sum_ff        <= sum_in;
      end
   end

   always_comb begin
      if (head_ff[3] != cfg.own_device_id) begin
         status = ST_DEVICE;
      end else if (head_ff[0] != cfg.header_first || head_ff[1] != cfg.header_second) begin
         status = ST_HEADER;
      end else if (tail_ff[2] != TAIL_Y || tail_ff[3] != TAIL_H || tail_ff[4] != TAIL_T) begin
         status = ST_TAIL;
      end else if (overflowed_ff || byte_count_ff < MIN_FRAME ||
                   {1'b0, head_ff[2]} != byte_count_ff) begin
         status = ST_LENGTH;
      end else if (tail_ff[0] != sum_ff[15:8] || tail_ff[1] != sum_ff[7:0]) begin
         status = ST_CHECKSUM;
      end else begin
         status = ST_OK;
      end
   end

   logic [7:0] payload_full;
   assign payload_full = byte_count_ff[7:0] - MIN_FRAME[7:0];

   assign done                  = accept && (req_kind == REQ_IDLE);
   assign result.frame_status   = status;
   assign result.frame_length   = byte_count_ff;
   assign result.payload_length = (status == ST_OK) ? payload_full : 8'd0;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= MaxCount)
      else $error("byte count above the frame maximum");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflowed_ff |-> byte_count_ff == MaxCount)
      else $error("overflow flagged on a frame that is not full");

   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      done |=> (byte_count_ff == 9'd0 && !overflowed_ff && sum_ff == 16'd0))
      else $error("frame state not cleared after an idle event");

   a_sum_early: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= 9'd5 |-> sum_ff == 16'd0)
      else $error("running sum moved before any byte left the window");

endmodule

`default_nettype wire

@@ hdl/ifpc_rsp_buf.sv @@
// Two-entry result buffer: an output register backed by a skid register.
// Lets the input side keep flowing while a result waits. Depends on ifpc_pkg.
`default_nettype none

module ifpc_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ifpc_pkg::rsp_type push_data,
   output logic              space,
   output logic              out_valid,
   input  logic              out_ready,
   output ifpc_pkg::rsp_type out_data
);
   import ifpc_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_data_ff;
   rsp_type skid_data_ff;
   logic    pop;

   assign pop = out_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         // No push can arrive while the skid register is full.
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end
      if (push && out_valid_ff && !pop) begin
         skid_data_ff <= push_data;
      end
   end

   assign space     = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result ahead of the output register");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed while both entries are full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid result lost when the output register drained");

endmodule

`default_nettype wire
